/* src/session_table_packet_steering_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the session table steering core
// Label, clocked property with synchronous reset disable, error report.
// ---------------------------------------------------------------------------
`ifndef SESSION_TABLE_PACKET_STEERING_CORE_MACROS_SVH
`define SESSION_TABLE_PACKET_STEERING_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define STPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Plain invariant that also holds during reset.
`define STPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* src/stps_pkg.sv */
// ---------------------------------------------------------------------------
// Session table steering package
// Verdict codes, protocol constants and the tuple carried along the chain.
// ---------------------------------------------------------------------------
package stps_pkg;

   localparam logic [1:0] VERDICT_DROP       = 2'd0;
   localparam logic [1:0] VERDICT_HOST       = 2'd1;
   localparam logic [1:0] VERDICT_REDIRECT   = 2'd2;
   localparam logic [1:0] VERDICT_CONTROLLER = 2'd3;

   localparam logic [15:0] ETHER_IPV4 = 16'h0800;
   localparam logic [15:0] ETHER_ARP  = 16'h0806;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [15:0] LEN_ETH       = 16'd14;
   localparam logic [15:0] LEN_ETH_ARP   = 16'd42;
   localparam logic [15:0] LEN_ETH_IPV4  = 16'd34;
   localparam logic [15:0] LEN_TCP_TOTAL = 16'd54;
   localparam logic [15:0] LEN_UDP_TOTAL = 16'd42;
   localparam logic [15:0] LEN_ICMP_TOTAL = 16'd42;
   localparam logic [15:0] CHAIN_SIDE_PORT = 16'd1;

   localparam logic [0:0] CSR_HOST_PORT  = 1'b0;
   localparam logic [0:0] CSR_CHAIN_PORT = 1'b1;

   typedef struct packed {
      logic [63:0] addr;
      logic [39:0] ports_proto;
   } tuple_type;

   // Probe travelling along the cell row.
   typedef struct packed {
      logic      active;
      logic      insert;
      tuple_type key;
      logic      hit;
      logic      done;
   } probe_type;

endpackage

/* src/session_table_packet_steering_core.sv */
// ---------------------------------------------------------------------------
// Session table packet steering core
// Classifies header summaries and tracks chain-side sessions in a row of
// entry cells.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_stall  header summary fields
// rsp      out  rsp_valid/rsp_stall  verdict, port, controller data, flags
// csr      in   csr_write            index, 16-bit data
// One item at a time. A tuple item reaches the result register once its probe has
// walked the cell row, one cell per cycle; any other item goes through the done
// state to the result register.
// Reset clears all entries and both port registers.
// A stalled result holds; the next request is taken from the cycle after it transfers.
// ---------------------------------------------------------------------------
module session_table_packet_steering_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_in_port,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_ethertype,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_echo_id,
   input  logic [31:0] req_arp_sender_ip,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_out_port,
   output logic [31:0] rsp_controller_data,
   output logic        rsp_entry_added,
   output logic        rsp_table_full,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   import stps_pkg::*;
   `include "session_table_packet_steering_core_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] host_port_ff, chain_port_ff;
   logic [1:0]  kind_ff;          // verdict of non-table items
   logic        chain_ff;
   logic [31:0] cdata_ff;
   logic [1:0]  rsp_verdict_ff;
   logic [15:0] rsp_out_port_ff;
   logic [31:0] rsp_cdata_ff;
   logic        rsp_added_ff, rsp_full_ff, rsp_valid_ff;

   probe_type   chain_c [TABLE_ENTRIES+1];
   probe_type   head_ff;

   logic        req_xfer, rsp_xfer;
   logic        ok;
   logic [1:0]  kind;
   logic [31:0] cdata;
   logic [15:0] sport, dport;
   tuple_type   key;
   probe_type   tail;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   always_comb begin
      ok    = 1'b0;
      kind  = VERDICT_DROP;
      cdata = '0;
      sport = req_source_port;
      dport = req_dest_port;
      if (req_frame_length < LEN_ETH) begin
         kind = VERDICT_DROP;
      end else if (req_ethertype == ETHER_ARP) begin
         if (req_frame_length >= LEN_ETH_ARP) begin
            kind  = VERDICT_CONTROLLER;
            cdata = req_arp_sender_ip;
         end
      end else if (req_ethertype != ETHER_IPV4 || req_frame_length < LEN_ETH_IPV4) begin
         kind = VERDICT_DROP;
      end else if (req_ip_protocol == PROTO_TCP) begin
         ok = req_frame_length >= LEN_TCP_TOTAL;
      end else if (req_ip_protocol == PROTO_UDP) begin
         ok = req_frame_length >= LEN_UDP_TOTAL;
      end else if (req_ip_protocol == PROTO_ICMP) begin
         ok    = req_frame_length >= LEN_ICMP_TOTAL;
         sport = req_echo_id;
         dport = req_echo_id;
      end
      if (req_in_port == CHAIN_SIDE_PORT) begin
         key.addr        = {req_src_ip, req_dst_ip};
         key.ports_proto = {sport, dport, req_ip_protocol};
      end else begin
         key.addr        = {req_dst_ip, req_src_ip};
         key.ports_proto = {dport, sport, req_ip_protocol};
      end
   end

   assign chain_c[0] = head_ff;

   genvar g;
   generate
      for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
         stps_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .probe_in  (chain_c[g]),
            .probe_out (chain_c[g+1])
         );
      end
   endgenerate

   assign tail = chain_c[TABLE_ENTRIES];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ok ? ST_WALK : ST_DONE;
         ST_WALK: if (tail.active) state_in = ST_IDLE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         host_port_ff   <= '0;
         chain_port_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         head_ff.active <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_HOST_PORT:  host_port_ff  <= csr_data;
               CSR_CHAIN_PORT: chain_port_ff <= csr_data;
            endcase
         end
         head_ff.active <= req_xfer && ok;
         head_ff.insert <= req_in_port == CHAIN_SIDE_PORT;
         head_ff.key    <= key;
         head_ff.hit    <= 1'b0;
         head_ff.done   <= 1'b0;
         if (req_xfer) begin
            kind_ff   <= kind;
            cdata_ff  <= cdata;
            chain_ff  <= req_in_port == CHAIN_SIDE_PORT;
         end
         if (rsp_xfer) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_DONE) begin
            rsp_valid_ff    <= 1'b1;
            rsp_verdict_ff  <= kind_ff;
            rsp_out_port_ff <= '0;
            rsp_cdata_ff    <= cdata_ff;
            rsp_added_ff    <= 1'b0;
            rsp_full_ff     <= 1'b0;
         end else if (state_ff == ST_WALK && tail.active) begin
            rsp_valid_ff <= 1'b1;
            rsp_cdata_ff <= '0;
            if (chain_ff) begin
               rsp_verdict_ff  <= VERDICT_REDIRECT;
               rsp_out_port_ff <= host_port_ff;
               rsp_added_ff    <= !tail.hit && tail.done;
               rsp_full_ff     <= !tail.done;
            end else begin
               rsp_verdict_ff  <= tail.hit ? VERDICT_REDIRECT : VERDICT_HOST;
               rsp_out_port_ff <= tail.hit ? chain_port_ff : 16'd0;
               rsp_added_ff    <= 1'b0;
               rsp_full_ff     <= 1'b0;
            end
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_out_port        = rsp_out_port_ff;
   assign rsp_controller_data = rsp_cdata_ff;
   assign rsp_entry_added     = rsp_added_ff;
   assign rsp_table_full      = rsp_full_ff;

   `STPS_ASSERT(a_no_take_while_busy, req_xfer |-> state_ff == ST_IDLE && !rsp_valid_ff,
                "request taken while busy")
   `STPS_ASSERT(a_flags_exclusive, rsp_valid |-> !(rsp_entry_added && rsp_table_full),
                "added and full together")
   `STPS_ASSERT(a_added_redirect,
                rsp_valid && rsp_entry_added |-> rsp_verdict == VERDICT_REDIRECT,
                "insert without redirect")
   `STPS_ASSERT_ALWAYS(a_state_onehot, $onehot(state_ff) || reset || $past(reset),
                "state not one-hot")

endmodule

/* src/stps_cell.sv */
// ---------------------------------------------------------------------------
// Session table cell
// Holds one entry; compares the passing probe, claims it as the first free
// slot on an insert, and hands the probe to the next cell.
// ---------------------------------------------------------------------------
module stps_cell (
   input  logic                clock,
   input  logic                reset,
   input  stps_pkg::probe_type probe_in,
   output stps_pkg::probe_type probe_out
);
   import stps_pkg::*;

   logic      valid_ff;
   tuple_type entry_ff;
   probe_type probe_ff;
   probe_type probe_in_c;
   logic      match;
   logic      claim;

   assign match = valid_ff && (entry_ff == probe_in.key);
   assign claim = probe_in.active && probe_in.insert && !probe_in.done && !valid_ff;

   always_comb begin
      probe_in_c = probe_in;
      if (probe_in.active && !probe_in.done) begin
         if (match) begin
            probe_in_c.hit  = 1'b1;
            probe_in_c.done = 1'b1;
         end else if (claim) begin
            probe_in_c.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         probe_ff.active <= 1'b0;
      end else begin
         probe_ff <= probe_in_c;
         if (claim && !match) begin
            valid_ff <= 1'b1;
            entry_ff <= probe_in.key;
         end
      end
   end

   assign probe_out = probe_ff;

endmodule
